@@ src/nearest_palette_color_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_defines
// Assertion macros used by the mapper top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_MAPPER_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_DEFINES_SVH

// same-cycle implication
`define NPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcm assertion failed");

// next-cycle implication
`define NPCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcm assertion failed");

`endif

@@ src/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg
// Types and constants of the nearest palette color mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npcm_pkg;

    localparam int NUM_ENTRIES  = 4;
    localparam int PALETTE_SIZE = 4;
    localparam int NUM_CH       = 3;
    localparam int CH_W         = 8;
    localparam int COLOR_W      = NUM_CH * CH_W;
    localparam int SQ_W         = 2 * CH_W;
    localparam int DIST_W       = 18;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = COLOR_W;

    localparam logic [IDX_W-1:0] NONE_INDEX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PAL0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAL1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAL2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAL3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

    localparam logic [COLOR_W-1:0] PAL0_RESET  = 24'd5801852;
    localparam logic [COLOR_W-1:0] PAL1_RESET  = 24'd14803425;
    localparam logic [COLOR_W-1:0] PAL2_RESET  = 24'd16777020;
    localparam logic [COLOR_W-1:0] PAL3_RESET  = 24'd8109492;
    localparam logic [DIST_W-1:0]  LIMIT_RESET = 18'd65025;

    typedef logic [COLOR_W-1:0] t_color;

    typedef struct packed {
        t_color [NUM_ENTRIES-1:0] palette;
        logic [DIST_W-1:0]        limit;
    } t_cfg;

    typedef struct packed {
        logic                                  valid;
        logic [PALETTE_SIZE-1:0][DIST_W-1:0]  sq_dist;
    } t_dist_beat;

endpackage

@@ src/npcm_pixel_if.sv @@
// ----------------------------------------------------------------------------
// npcm_pixel_if
// Pixel input channel: valid/ready with three 8-bit channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npcm_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [npcm_pkg::CH_W-1:0] pixel_ch0;
    logic [npcm_pkg::CH_W-1:0] pixel_ch1;
    logic [npcm_pkg::CH_W-1:0] pixel_ch2;

    modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, input ready);
    modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

@@ src/npcm_result_if.sv @@
// ----------------------------------------------------------------------------
// npcm_result_if
// Result channel: valid/ready with mapped color and matched index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npcm_result_if;
    logic                       valid;
    logic                       ready;
    logic [npcm_pkg::CH_W-1:0]  mapped_ch0;
    logic [npcm_pkg::CH_W-1:0]  mapped_ch1;
    logic [npcm_pkg::CH_W-1:0]  mapped_ch2;
    logic [npcm_pkg::IDX_W-1:0] matched_index;

    modport source (output valid, mapped_ch0, mapped_ch1, mapped_ch2, matched_index,
                    input ready);
    modport sink   (input valid, mapped_ch0, mapped_ch1, mapped_ch2, matched_index,
                    output ready);
endinterface

@@ src/npcm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// npcm_cfg_regs
// Palette and distance limit registers behind the write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npcm_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [npcm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [npcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output npcm_pkg::t_cfg                      o_cfg
);

    npcm_pkg::t_cfg r_cfg;
    npcm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                npcm_pkg::REG_PAL0:  n_cfg.palette[0] = i_cfg_data;
                npcm_pkg::REG_PAL1:  n_cfg.palette[1] = i_cfg_data;
                npcm_pkg::REG_PAL2:  n_cfg.palette[2] = i_cfg_data;
                npcm_pkg::REG_PAL3:  n_cfg.palette[3] = i_cfg_data;
                npcm_pkg::REG_LIMIT: n_cfg.limit = i_cfg_data[npcm_pkg::DIST_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette[0] <= npcm_pkg::PAL0_RESET;
            r_cfg.palette[1] <= npcm_pkg::PAL1_RESET;
            r_cfg.palette[2] <= npcm_pkg::PAL2_RESET;
            r_cfg.palette[3] <= npcm_pkg::PAL3_RESET;
            r_cfg.limit      <= npcm_pkg::LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/npcm_dist_pipe.sv @@
// ----------------------------------------------------------------------------
// npcm_dist_pipe
// Three-stage squared distance pipe: abs diff, square, channel sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npcm_dist_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  npcm_pkg::t_cfg        i_cfg,
    npcm_pixel_if.sink            i_pix,
    output npcm_pkg::t_dist_beat  o_dist,
    input  logic                  i_dist_ready
);

    localparam int P  = npcm_pkg::PALETTE_SIZE;
    localparam int C  = npcm_pkg::NUM_CH;
    localparam int W  = npcm_pkg::CH_W;
    localparam int SW = npcm_pkg::SQ_W;
    localparam int DW = npcm_pkg::DIST_W;

    logic                         r_s1_valid;
    logic                         r_s2_valid;
    logic                         r_s3_valid;
    logic [P-1:0][C-1:0][W-1:0]   r_s1_diff;
    logic [P-1:0][C-1:0][SW-1:0]  r_s2_sq;
    logic [P-1:0][DW-1:0]         r_s3_dist;

    logic [P-1:0][C-1:0][W-1:0]   n_s1_diff;
    logic [P-1:0][C-1:0][SW-1:0]  n_s2_sq;
    logic [P-1:0][DW-1:0]         n_s3_dist;
    logic [C-1:0][W-1:0]          pix;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready    = !r_s3_valid || i_dist_ready;
    assign s2_ready    = !r_s2_valid || s3_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_pix.ready = s1_ready;

    assign pix[0] = i_pix.pixel_ch0;
    assign pix[1] = i_pix.pixel_ch1;
    assign pix[2] = i_pix.pixel_ch2;

    always_comb begin
        for (int e = 0; e < P; e++) begin
            for (int c = 0; c < C; c++) begin
                if (pix[c] > i_cfg.palette[e][c*W +: W]) begin
                    n_s1_diff[e][c] = pix[c] - i_cfg.palette[e][c*W +: W];
                end else begin
                    n_s1_diff[e][c] = i_cfg.palette[e][c*W +: W] - pix[c];
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < P; e++) begin
            for (int c = 0; c < C; c++) begin
                n_s2_sq[e][c] = SW'(r_s1_diff[e][c]) * SW'(r_s1_diff[e][c]);
            end
        end
    end

    always_comb begin
        for (int e = 0; e < P; e++) begin
            n_s3_dist[e] = DW'(r_s2_sq[e][0]) + DW'(r_s2_sq[e][1]) + DW'(r_s2_sq[e][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_pix.valid;
            if (s2_ready) r_s2_valid <= r_s1_valid;
            if (s3_ready) r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) r_s1_diff <= n_s1_diff;
        if (s2_ready) r_s2_sq   <= n_s2_sq;
        if (s3_ready) r_s3_dist <= n_s3_dist;
    end

    assign o_dist.valid   = r_s3_valid;
    assign o_dist.sq_dist = r_s3_dist;

endmodule

@@ src/npcm_select.sv @@
// ----------------------------------------------------------------------------
// npcm_select
// Picks the nearest entry under the limit and holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npcm_select (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  npcm_pkg::t_cfg        i_cfg,
    input  npcm_pkg::t_dist_beat  i_dist,
    output logic                  o_dist_ready,
    npcm_result_if.source         o_res
);

    localparam int W = npcm_pkg::CH_W;

    logic                           r_valid;
    npcm_pkg::t_color               r_color;
    logic [npcm_pkg::IDX_W-1:0]     r_index;

    npcm_pkg::t_color               n_color;
    logic [npcm_pkg::IDX_W-1:0]     n_index;
    logic [npcm_pkg::DIST_W-1:0]    best;
    logic                           stage_ready;

    assign stage_ready  = !r_valid || o_res.ready;
    assign o_dist_ready = stage_ready;

    // strict compare keeps the lower index on ties
    always_comb begin
        best    = i_cfg.limit;
        n_color = '0;
        n_index = npcm_pkg::NONE_INDEX;
        for (int e = 0; e < npcm_pkg::PALETTE_SIZE; e++) begin
            if (i_dist.sq_dist[e] < best) begin
                best    = i_dist.sq_dist[e];
                n_color = i_cfg.palette[e];
                n_index = npcm_pkg::IDX_W'(e);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_dist.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready) begin
            r_color <= n_color;
            r_index <= n_index;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.mapped_ch0    = r_color[0*W +: W];
    assign o_res.mapped_ch1    = r_color[1*W +: W];
    assign o_res.mapped_ch2    = r_color[2*W +: W];
    assign o_res.matched_index = r_index;

endmodule

@@ src/nearest_palette_color_mapper.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Pipeline: registered diff, square, sum and select stages, pixel beat to result beat.
// Throughput: one pixel per cycle; each stage stalls only when it and all
// stages after it hold beats and the result is not taken.
// Reset: synchronous active low; clears pipe valids, loads default palette
// and limit. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_palette_color_mapper_defines.svh"

module nearest_palette_color_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [npcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [npcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    npcm_pixel_if.sink                       i_pix,
    npcm_result_if.source                    o_res
);

    npcm_pkg::t_cfg        cfg;
    npcm_pkg::t_dist_beat  dist_beat;
    logic                  dist_ready;

    npcm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    npcm_dist_pipe u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pix        (i_pix),
        .o_dist       (dist_beat),
        .i_dist_ready (dist_ready)
    );

    npcm_select u_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_dist       (dist_beat),
        .o_dist_ready (dist_ready),
        .o_res        (o_res)
    );

    // no match gives black
    `NPCM_ASSERT_IMP(a_none_black, i_clk, i_rst_n,
        o_res.valid && (o_res.matched_index == npcm_pkg::NONE_INDEX),
        (o_res.mapped_ch0 == '0) && (o_res.mapped_ch1 == '0) && (o_res.mapped_ch2 == '0))

    `NPCM_ASSERT_IMP(a_index_range, i_clk, i_rst_n, o_res.valid,
        (o_res.matched_index == npcm_pkg::NONE_INDEX) ||
        (o_res.matched_index < npcm_pkg::IDX_W'(npcm_pkg::PALETTE_SIZE)))

    // input backpressure only when the whole pipe is full behind a stalled result
    `NPCM_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !i_pix.ready,
        o_res.valid && !o_res.ready && dist_beat.valid)

endmodule
